[sv/clcp_column_score_accumulator_top_defines.svh]
// Assertion macros for the column score accumulator.
// Used by clcp_column_score_accumulator_top; expects clk and rst in scope.
`ifndef CLCP_COLUMN_SCORE_ACCUMULATOR_TOP_DEFINES_SVH
`define CLCP_COLUMN_SCORE_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CLCP_ASSERT_IMPL(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("clcp assertion failed");
`define CLCP_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("clcp assertion failed");
`else
`define CLCP_ASSERT_IMPL(lbl, cond, expr)
`define CLCP_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

[sv/clcp_pkg.sv]
// Shared constants, codes and types of the column score accumulator.
// No dependencies; used by every module of the block.
package clcp_pkg;

  localparam int MAX_SEQUENCES = 1024;
  localparam int LCP_BITS      = 16;
  localparam int SCORE_BITS    = 40;
  localparam int SEQ_BITS      = 10;
  localparam int REQ_BITS      = 2;
  localparam int ADDR_BITS     = $clog2(MAX_SEQUENCES);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  // request codes on the input channel
  localparam logic [REQ_BITS-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_ELEMENT = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_READ    = 2'd2;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED  = 2'd3;

  // operations handed from front to back
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [SEQ_BITS-1:0] seq;
    logic [LCP_BITS-1:0] added;
    logic                last;
  } clcp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } clcp_queue_status_t;

  typedef struct packed {
    logic pop;
    logic clearing;
    logic s1_valid;
  } clcp_back_status_t;

endpackage

[sv/clcp_front.sv]
// Front end: accepts transactions, keeps the running alpha/zeta/reference state
// and classifies each request into a queue entry. Depends on clcp_pkg.
module clcp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [clcp_pkg::REQ_BITS-1:0]       req_type,
  input  logic [clcp_pkg::LCP_BITS-1:0]       element_lcp,
  input  logic [clcp_pkg::SEQ_BITS-1:0]       element_sequence,
  input  logic                                d_position_hit,
  input  logic [clcp_pkg::LCP_BITS-1:0]       d_pair_lcp,
  input  logic [clcp_pkg::LCP_BITS-1:0]       next_ref_lcp,
  input  logic                                next_ref_lcp_valid,
  input  logic                                last_element,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clcp_pkg::SEQ_BITS-1:0]       cfg_data,
  input  clcp_pkg::clcp_queue_status_t        q_status,
  output logic                                push,
  output clcp_pkg::clcp_entry_t               push_entry
);

  logic [clcp_pkg::SEQ_BITS-1:0] reference_sequence;
  logic [clcp_pkg::LCP_BITS-1:0] min_lcp_run, min_lcp_run_next;
  logic [clcp_pkg::LCP_BITS-1:0] max_d_run, max_d_run_next;
  logic                          first_pending, first_pending_next;
  logic [clcp_pkg::LCP_BITS-1:0] ref_lcp_current, ref_lcp_current_next;

  logic                          accept;
  logic                          foreign;
  logic [clcp_pkg::LCP_BITS-1:0] min_new;
  logic [clcp_pkg::LCP_BITS-1:0] max_new;
  logic [clcp_pkg::LCP_BITS-1:0] amount;
  logic [clcp_pkg::LCP_BITS-1:0] ref_load;

  assign in_ready  = !q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign foreign  = (element_sequence != reference_sequence);
  assign min_new  = (element_lcp < min_lcp_run) ? element_lcp : min_lcp_run;
  assign max_new  = (d_position_hit && (d_pair_lcp > max_d_run)) ? d_pair_lcp : max_d_run;
  assign ref_load = next_ref_lcp_valid ? next_ref_lcp : '0;

  // when alpha does not exceed the reference LCP, max of all three
  // reduces to max(zeta, reference LCP)
  always_comb begin
    if (first_pending) begin
      amount = max_new;
    end else if (min_new > ref_lcp_current) begin
      amount = min_new;
    end else begin
      amount = (max_new > ref_lcp_current) ? max_new : ref_lcp_current;
    end
  end

  always_comb begin
    min_lcp_run_next     = min_lcp_run;
    max_d_run_next       = max_d_run;
    first_pending_next   = first_pending;
    ref_lcp_current_next = ref_lcp_current;
    push                 = 1'b0;
    push_entry.op        = clcp_pkg::OP_READ;
    push_entry.seq       = element_sequence;
    push_entry.added     = '0;
    push_entry.last      = 1'b0;
    unique case (req_type)
      clcp_pkg::REQ_START: begin
        min_lcp_run_next     = '1;
        max_d_run_next       = '0;
        first_pending_next   = 1'b1;
        ref_lcp_current_next = ref_load;
        push                 = accept;
        push_entry.op        = clcp_pkg::OP_START;
        push_entry.seq       = '0;
      end
      clcp_pkg::REQ_ELEMENT: begin
        push            = accept;
        push_entry.last = last_element;
        if (foreign) begin
          min_lcp_run_next   = min_new;
          max_d_run_next     = max_new;
          first_pending_next = 1'b0;
          push_entry.op      = clcp_pkg::OP_ADD;
          push_entry.added   = amount;
        end else begin
          min_lcp_run_next     = '1;
          max_d_run_next       = '0;
          ref_lcp_current_next = ref_load;
          if (!next_ref_lcp_valid) begin
            first_pending_next = 1'b0;
          end
        end
      end
      clcp_pkg::REQ_READ: begin
        push = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_sequence <= '0;
      min_lcp_run        <= '1;
      max_d_run          <= '0;
      first_pending      <= 1'b1;
      ref_lcp_current    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reference_sequence <= cfg_data;
      end
      if (accept) begin
        min_lcp_run     <= min_lcp_run_next;
        max_d_run       <= max_d_run_next;
        first_pending   <= first_pending_next;
        ref_lcp_current <= ref_lcp_current_next;
      end
    end
  end

endmodule

[sv/clcp_queue.sv]
// Short FIFO of classified operations between front and back.
// Depends on clcp_pkg for the entry type and depth.
module clcp_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  clcp_pkg::clcp_entry_t        push_entry,
  input  logic                         pop,
  output clcp_pkg::clcp_entry_t        head,
  output clcp_pkg::clcp_queue_status_t status
);

  clcp_pkg::clcp_entry_t          slots [clcp_pkg::QUEUE_DEPTH];
  logic [clcp_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [clcp_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [clcp_pkg::QPTR_BITS:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign status.full  = (count == (clcp_pkg::QPTR_BITS+1)'(clcp_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/clcp_back.sv]
// Back end: score column memory with read-modify-write, forwarding,
// saturation, clearing pass and the output register. Depends on clcp_pkg.
module clcp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  clcp_pkg::clcp_entry_t               head,
  input  clcp_pkg::clcp_queue_status_t        q_status,
  output clcp_pkg::clcp_back_status_t         status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clcp_pkg::SEQ_BITS-1:0]       score_sequence,
  output logic [clcp_pkg::LCP_BITS-1:0]       added_amount,
  output logic [clcp_pkg::SCORE_BITS-1:0]     score_value,
  output logic                                column_done
);

  logic [clcp_pkg::SCORE_BITS-1:0] score_mem [clcp_pkg::MAX_SEQUENCES];

  logic                             s1_valid;
  clcp_pkg::clcp_entry_t            s1;
  logic [clcp_pkg::SCORE_BITS-1:0]  rdata;
  logic                             last_wr_valid;
  logic [clcp_pkg::ADDR_BITS-1:0]   last_wr_addr;
  logic [clcp_pkg::SCORE_BITS-1:0]  last_wr_data;
  logic                             clearing;
  logic [clcp_pkg::ADDR_BITS-1:0]   clr_addr;

  logic                             adv;
  logic                             s1_is_start;
  logic                             pop;
  logic                             in_range;
  logic [clcp_pkg::ADDR_BITS-1:0]   addr;
  logic [clcp_pkg::SCORE_BITS-1:0]  cur;
  logic [clcp_pkg::SCORE_BITS:0]    sum;
  logic [clcp_pkg::SCORE_BITS-1:0]  sat;
  logic                             do_write;
  logic [clcp_pkg::SCORE_BITS-1:0]  res_score;

  assign adv         = !s1_valid || !out_valid || out_ready;
  assign s1_is_start = s1_valid && (s1.op == clcp_pkg::OP_START);
  // hold the queue while a start waits in stage 1 so nothing reads stale scores
  assign pop         = adv && !clearing && !s1_is_start && !q_status.empty;

  assign in_range = (32'(s1.seq) < 32'(clcp_pkg::MAX_SEQUENCES));
  assign addr     = s1.seq[clcp_pkg::ADDR_BITS-1:0];
  // the write retired at the edge of our read is the only one it can miss
  assign cur      = (last_wr_valid && (last_wr_addr == addr)) ? last_wr_data : rdata;
  assign sum      = {1'b0, cur} + (clcp_pkg::SCORE_BITS+1)'(s1.added);
  assign sat      = sum[clcp_pkg::SCORE_BITS] ? '1 : sum[clcp_pkg::SCORE_BITS-1:0];
  assign do_write = adv && s1_valid && (s1.op == clcp_pkg::OP_ADD) && in_range;

  always_comb begin
    res_score = '0;
    if (in_range) begin
      if (s1.op == clcp_pkg::OP_ADD) begin
        res_score = sat;
      end else if (s1.op == clcp_pkg::OP_READ) begin
        res_score = cur;
      end
    end
  end

  assign status.pop      = pop;
  assign status.clearing = clearing;
  assign status.s1_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (clearing) begin
      score_mem[clr_addr] <= '0;
    end else if (do_write) begin
      score_mem[addr] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= score_mem[head.seq[clcp_pkg::ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= head;
    end
    if (do_write) begin
      last_wr_addr <= addr;
      last_wr_data <= sat;
    end
    if (adv && s1_valid) begin
      score_sequence <= s1.seq;
      added_amount   <= s1.added;
      score_value    <= res_score;
      column_done    <= s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      last_wr_valid <= 1'b0;
      clearing      <= 1'b1;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= pop;
      end
      if (clearing) begin
        last_wr_valid <= 1'b0;
        clr_addr      <= clr_addr + 1'b1;
        if (clr_addr == clcp_pkg::ADDR_BITS'(clcp_pkg::MAX_SEQUENCES - 1)) begin
          clearing <= 1'b0;
        end
      end else if (adv && s1_is_start) begin
        clearing      <= 1'b1;
        clr_addr      <= '0;
        last_wr_valid <= 1'b0;
      end else if (do_write) begin
        last_wr_valid <= 1'b1;
      end
      if (adv && s1_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/clcp_column_score_accumulator_top.sv]
// Top level of the column score accumulator: front, queue and back joined.
// Depends on clcp_pkg, clcp_front, clcp_queue, clcp_back and the defines header.
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transaction:
//   start column, BWT element or read score. Output channel
//   (out_valid/out_ready) returns exactly one result transaction per start,
//   element or read request, in order; request code 3 is taken and dropped.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes reference_sequence;
//   cfg_ready is always high. Write it only while the block is idle.
// Throughput: one request per cycle while the queue is not full. Alpha/zeta
//   tracking runs in the front at acceptance; each score update reads the
//   memory on pop and writes it from s1 (one read port, one write port),
//   forwarding the previous write. Path: queue slot, s1, output register.
// Clearing: after reset, and after a start request's result is issued, the
//   score memory is zeroed at one entry per cycle. During that pass the back
//   end takes nothing from the 4-entry queue; the front keeps accepting until
//   the queue fills, then drops in_ready.
// Stall: when out_ready is low the result holds in the output register, the
//   back end stops and the queue fills; in_ready falls once it is full.
// Reset: rst is synchronous, active high; state and reference_sequence clear.
`include "clcp_column_score_accumulator_top_defines.svh"

module clcp_column_score_accumulator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [clcp_pkg::REQ_BITS-1:0]   req_type,
  input  logic [clcp_pkg::LCP_BITS-1:0]   element_lcp,
  input  logic [clcp_pkg::SEQ_BITS-1:0]   element_sequence,
  input  logic                            d_position_hit,
  input  logic [clcp_pkg::LCP_BITS-1:0]   d_pair_lcp,
  input  logic [clcp_pkg::LCP_BITS-1:0]   next_ref_lcp,
  input  logic                            next_ref_lcp_valid,
  input  logic                            last_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [clcp_pkg::SEQ_BITS-1:0]   score_sequence,
  output logic [clcp_pkg::LCP_BITS-1:0]   added_amount,
  output logic [clcp_pkg::SCORE_BITS-1:0] score_value,
  output logic                            column_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clcp_pkg::SEQ_BITS-1:0]   cfg_data
);

  clcp_pkg::clcp_queue_status_t q_status;
  clcp_pkg::clcp_back_status_t  bk_status;
  clcp_pkg::clcp_entry_t        push_entry;
  clcp_pkg::clcp_entry_t        head;
  logic                         push;

  // front: running state and classification, no score access
  clcp_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .element_lcp        (element_lcp),
    .element_sequence   (element_sequence),
    .d_position_hit     (d_position_hit),
    .d_pair_lcp         (d_pair_lcp),
    .next_ref_lcp       (next_ref_lcp),
    .next_ref_lcp_valid (next_ref_lcp_valid),
    .last_element       (last_element),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .q_status           (q_status),
    .push               (push),
    .push_entry         (push_entry)
  );

  // decoupling queue; lets the front run on during clearing or output stalls
  clcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (bk_status.pop),
    .head       (head),
    .status     (q_status)
  );

  // back: score memory and output register
  clcp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .status         (bk_status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .score_sequence (score_sequence),
    .added_amount   (added_amount),
    .score_value    (score_value),
    .column_done    (column_done)
  );

  // no operation leaves the queue while the memory is being zeroed
  `CLCP_ASSERT_IMPL(a_no_pop_while_clearing, bk_status.clearing, !bk_status.pop)
  // the back end only pops a queue that holds something
  `CLCP_ASSERT_IMPL(a_pop_nonempty, bk_status.pop, !q_status.empty)
  // a stalled output with stage 1 occupied freezes the back end
  `CLCP_ASSERT_IMPL(a_stall_holds, bk_status.s1_valid && out_valid && !out_ready, !bk_status.pop)
  // a pushed transaction is visible in the queue on the next cycle
  `CLCP_ASSERT_NEXT(a_push_lands, push, !q_status.empty)

endmodule

[verif/clcp_column_score_checker.sv]
// Checker for the column score accumulator: tracks alpha, zeta, the first flag,
// the reference LCP and the score column, and compares every result transaction.
// Depends on clcp_pkg for widths and request codes.
`timescale 1ns / 1ps

module clcp_column_score_checker
  import clcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [REQ_BITS-1:0]   req_type,
  input  logic [LCP_BITS-1:0]   element_lcp,
  input  logic [SEQ_BITS-1:0]   element_sequence,
  input  logic                  d_position_hit,
  input  logic [LCP_BITS-1:0]   d_pair_lcp,
  input  logic [LCP_BITS-1:0]   next_ref_lcp,
  input  logic                  next_ref_lcp_valid,
  input  logic                  last_element,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SEQ_BITS-1:0]   score_sequence,
  input  logic [LCP_BITS-1:0]   added_amount,
  input  logic [SCORE_BITS-1:0] score_value,
  input  logic                  column_done,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [SEQ_BITS-1:0]   cfg_data,
  output int                    failures,
  output int                    outstanding,
  output int                    results_checked
);

  typedef struct packed {
    logic [SEQ_BITS-1:0]   seq;
    logic [LCP_BITS-1:0]   added;
    logic [SCORE_BITS-1:0] score;
    logic                  done;
  } score_result_t;

  score_result_t         expected_scores[$];
  logic [SCORE_BITS-1:0] score_mem[MAX_SEQUENCES];
  logic [SEQ_BITS-1:0]   ref_seq;
  logic [LCP_BITS-1:0]   alpha_run;
  logic [LCP_BITS-1:0]   zeta_run;
  logic [LCP_BITS-1:0]   ref_lcp;
  logic                  first_flag;
  int                    fail_count = 0;
  int                    result_count = 0;
  int                    pending_count = 0;

  assign failures        = fail_count;
  assign results_checked = result_count;
  assign outstanding     = pending_count;

  task automatic clear_column();
    alpha_run  = '1;
    zeta_run   = '0;
    first_flag = 1'b1;
    ref_lcp    = '0;
    for (int i = 0; i < MAX_SEQUENCES; i++) score_mem[i] = '0;
  endtask

  task automatic predict_request(
    input logic [REQ_BITS-1:0] req,
    input logic [LCP_BITS-1:0] lcp,
    input logic [SEQ_BITS-1:0] seq,
    input logic                hit,
    input logic [LCP_BITS-1:0] dlcp,
    input logic [LCP_BITS-1:0] nref,
    input logic                nvalid,
    input logic                last
  );
    score_result_t       r;
    logic [LCP_BITS-1:0] amount;
    logic [SCORE_BITS:0] sum;
    r      = '0;
    amount = '0;
    case (req)
      REQ_START: begin
        clear_column();
        ref_lcp = nvalid ? nref : '0;
        expected_scores.push_back(r);
      end
      REQ_READ: begin
        r.seq   = seq;
        r.score = (seq < MAX_SEQUENCES) ? score_mem[seq] : '0;
        expected_scores.push_back(r);
      end
      REQ_ELEMENT: begin
        if (seq != ref_seq) begin
          if (lcp < alpha_run) alpha_run = lcp;
          if (hit && dlcp > zeta_run) zeta_run = dlcp;
          if (first_flag) begin
            first_flag = 1'b0;
            amount     = zeta_run;
          end else if (alpha_run > ref_lcp) begin
            amount = alpha_run;
          end else begin
            amount = alpha_run;
            if (zeta_run > amount) amount = zeta_run;
            if (ref_lcp > amount) amount = ref_lcp;
          end
          if (seq < MAX_SEQUENCES) begin
            // saturating add into the score entry
            sum            = {1'b0, score_mem[seq]} + amount;
            score_mem[seq] = sum[SCORE_BITS] ? '1 : sum[SCORE_BITS-1:0];
            r.score        = score_mem[seq];
          end
        end else begin
          // reference position: D hit ignored, run values restart
          alpha_run = '1;
          zeta_run  = '0;
          if (nvalid) begin
            ref_lcp = nref;
          end else begin
            ref_lcp    = '0;
            first_flag = 1'b0;
          end
          if (seq < MAX_SEQUENCES) r.score = score_mem[seq];
        end
        r.seq   = seq;
        r.added = amount;
        r.done  = last;
        expected_scores.push_back(r);
      end
      default: ;  // unused code: taken, no result
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    score_result_t exp_r;
    if (rst) begin
      ref_seq = '0;
      clear_column();
      expected_scores.delete();
    end else begin
      if (cfg_valid && cfg_ready) ref_seq = cfg_data;
      if (in_valid && in_ready)
        predict_request(req_type, element_lcp, element_sequence, d_position_hit,
                        d_pair_lcp, next_ref_lcp, next_ref_lcp_valid, last_element);
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_scores.size() == 0) begin
          $error("result transaction with nothing expected: score_sequence %0d",
                 score_sequence);
          fail_count++;
        end else begin
          exp_r = expected_scores.pop_front();
          check_field("score_sequence", exp_r.seq, score_sequence);
          check_field("added_amount", exp_r.added, added_amount);
          check_field("score_value", exp_r.score, score_value);
          check_field("column_done", exp_r.done, column_done);
        end
      end
    end
    pending_count <= expected_scores.size();
  end

endmodule

[verif/clcp_column_score_accumulator_top_tb.sv]
// Testbench top for the column score accumulator: clock, reset, stimulus and verdict.
// Depends on clcp_pkg, clcp_column_score_accumulator_top and clcp_column_score_checker.
`timescale 1ns / 1ps

module clcp_column_score_accumulator_top_tb;
  import clcp_pkg::*;

  localparam int HALF_PERIOD    = 5;
  // Longest quiet stretch of a correct run is the clearing pass after a start
  // plus a receiver stall; allow several times that.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;     // margin for results still in flight
  localparam int RANDOM_ITEMS   = 1900;
  localparam int QUIET_ITEMS    = 200;   // tail of the run with no idling

  typedef struct packed {
    logic [REQ_BITS-1:0] req;
    logic [LCP_BITS-1:0] lcp;
    logic [SEQ_BITS-1:0] seq;
    logic                hit;
    logic [LCP_BITS-1:0] dlcp;
    logic [LCP_BITS-1:0] nref;
    logic                nvalid;
    logic                last;
  } request_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [REQ_BITS-1:0]   req_type = REQ_START;
  logic [LCP_BITS-1:0]   element_lcp = '0;
  logic [SEQ_BITS-1:0]   element_sequence = '0;
  logic                  d_position_hit = 1'b0;
  logic [LCP_BITS-1:0]   d_pair_lcp = '0;
  logic [LCP_BITS-1:0]   next_ref_lcp = '0;
  logic                  next_ref_lcp_valid = 1'b0;
  logic                  last_element = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEQ_BITS-1:0]   score_sequence;
  logic [LCP_BITS-1:0]   added_amount;
  logic [SCORE_BITS-1:0] score_value;
  logic                  column_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SEQ_BITS-1:0]   cfg_data = '0;

  int failures;
  int outstanding;
  int results_checked;

  // Knobs shared by the sender and the receiver
  int                  idle_pct = 0;    // chance of a sender gap after each transaction
  int                  stall_pct = 0;   // chance of a receiver stall burst
  int                  stall_left = 0;
  int                  idle_cycles = 0;
  int                  sent_count = 0;
  int                  column_count = 0;
  int                  cfg_count = 0;
  logic [SEQ_BITS-1:0] ref_id = '0;     // reference sequence currently programmed

  wire activity = (in_valid && in_ready) || (out_valid && out_ready) ||
                  (cfg_valid && cfg_ready);

  always #HALF_PERIOD clk = ~clk;

  clcp_column_score_accumulator_top uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .element_lcp        (element_lcp),
    .element_sequence   (element_sequence),
    .d_position_hit     (d_position_hit),
    .d_pair_lcp         (d_pair_lcp),
    .next_ref_lcp       (next_ref_lcp),
    .next_ref_lcp_valid (next_ref_lcp_valid),
    .last_element       (last_element),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .score_sequence     (score_sequence),
    .added_amount       (added_amount),
    .score_value        (score_value),
    .column_done        (column_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  clcp_column_score_checker u_score_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .element_lcp        (element_lcp),
    .element_sequence   (element_sequence),
    .d_position_hit     (d_position_hit),
    .d_pair_lcp         (d_pair_lcp),
    .next_ref_lcp       (next_ref_lcp),
    .next_ref_lcp_valid (next_ref_lcp_valid),
    .last_element       (last_element),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .score_sequence     (score_sequence),
    .added_amount       (added_amount),
    .score_value        (score_value),
    .column_done        (column_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .failures           (failures),
    .outstanding        (outstanding),
    .results_checked    (results_checked)
  );

  // Receiver: ready drops in bursts counted down in stall_left; one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no transaction completes on any channel.
  always @(posedge clk) begin
    if (rst || activity) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Small LCP values make alpha, zeta and the reference LCP collide often, so
  // every branch of the amount choice is hit; a few full-range values keep the
  // upper bits moving.
  function automatic logic [LCP_BITS-1:0] lcp_value();
    if ($urandom_range(0, 99) < 85) return LCP_BITS'($urandom_range(0, 48));
    return LCP_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.req    = REQ_BITS'($urandom_range(0, 3));
    r.lcp    = LCP_BITS'($urandom);
    r.seq    = SEQ_BITS'($urandom);
    r.hit    = 1'($urandom);
    r.dlcp   = LCP_BITS'($urandom);
    r.nref   = LCP_BITS'($urandom);
    r.nvalid = 1'($urandom);
    r.last   = 1'($urandom);
    return r;
  endfunction

  function automatic request_t make_request(
    input logic [REQ_BITS-1:0] req, input int lcp, input int seq, input logic hit,
    input int dlcp, input int nref, input logic nvalid, input logic last
  );
    request_t r;
    r.req    = req;
    r.lcp    = LCP_BITS'(lcp);
    r.seq    = SEQ_BITS'(seq);
    r.hit    = hit;
    r.dlcp   = LCP_BITS'(dlcp);
    r.nref   = LCP_BITS'(nref);
    r.nvalid = nvalid;
    r.last   = last;
    return r;
  endfunction

  // Present one request transaction and hold it until accepted, then maybe
  // leave a gap. Valid is only lowered when a gap follows.
  task automatic send_request(input request_t r);
    in_valid           <= 1'b1;
    req_type           <= r.req;
    element_lcp        <= r.lcp;
    element_sequence   <= r.seq;
    d_position_hit     <= r.hit;
    d_pair_lcp         <= r.dlcp;
    next_ref_lcp       <= r.nref;
    next_ref_lcp_valid <= r.nvalid;
    last_element       <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Sender holds off until every expected result has come back. The wait before
  // the first check lets the checker's count catch up with the last accepted one.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Reprogram the reference id with the block idle. Request code 3 leaves no
  // result behind, so give the pipeline its latency before writing.
  task automatic write_reference(input logic [SEQ_BITS-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ref_id = value;
    cfg_count++;
  endtask

  // Hand-picked requests with reference id 0: first flag, alpha above and below
  // the reference LCP, D hit on a reference position, exhausted reference
  // stream, unused code, element after the last one, reads of untouched ids.
  task automatic run_directed();
    send_request(make_request(REQ_START, 0, 0, 1'b0, 0, 5, 1'b1, 1'b0));
    send_request(make_request(REQ_ELEMENT, 65535, 1, 1'b1, 65535, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 10, 1023, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 3, 2, 1'b1, 4, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 20, 0, 1'b1, 9, 0, 1'b1, 1'b0));
    send_request(make_request(REQ_ELEMENT, 0, 1, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 5, 0, 1'b0, 0, 65535, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 7, 2, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_UNUSED, 65535, 1023, 1'b1, 65535, 65535, 1'b1, 1'b1));
    send_request(make_request(REQ_ELEMENT, 2, 1, 1'b1, 65535, 0, 1'b0, 1'b1));
    send_request(make_request(REQ_ELEMENT, 1, 1023, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 1, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 1023, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 2, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 512, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0));
    // start with an empty reference stream
    send_request(make_request(REQ_START, 0, 0, 1'b0, 0, 65535, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 4, 3, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_ELEMENT, 65535, 3, 1'b1, 12, 0, 1'b0, 1'b1));
    send_request(make_request(REQ_READ, 0, 3, 1'b0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(REQ_READ, 0, 1, 1'b0, 0, 0, 1'b0, 1'b0));
    drain();
  endtask

  // One column pass: start, a stream of elements over a few foreign ids with
  // reference positions mixed in, then score reads. Some noise throughout.
  task automatic run_column();
    request_t            r;
    logic [SEQ_BITS-1:0] pool[4];
    int                  n_elems;
    int                  last_idx;
    int                  n_reads;
    int                  ref_left;
    int                  roll;
    n_elems  = $urandom_range(20, 120);
    last_idx = n_elems - 1 - (($urandom_range(0, 3) == 0) ? 1 : 0);
    n_reads  = $urandom_range(4, 10);
    ref_left = $urandom_range(0, 12);
    for (int k = 0; k < 4; k++) pool[k] = SEQ_BITS'($urandom);
    column_count++;

    r        = random_request();
    r.req    = REQ_START;
    r.nvalid = (ref_left > 0) || ($urandom_range(0, 3) == 0);
    r.nref   = lcp_value();
    if (ref_left > 0) ref_left--;
    send_request(r);

    for (int k = 0; k < n_elems; k++) begin
      r      = random_request();
      r.req  = REQ_ELEMENT;
      r.lcp  = lcp_value();
      r.dlcp = lcp_value();
      r.nref = lcp_value();
      r.hit  = ($urandom_range(0, 99) < 30);
      r.last = (k == last_idx);
      if ($urandom_range(0, 99) < 20) begin
        // reference-colored position pulls the next reference LCP
        r.seq    = ref_id;
        r.nvalid = (ref_left > 0);
        if (ref_left > 0) ref_left--;
      end else if ($urandom_range(0, 9) != 0) begin
        r.seq = pool[$urandom_range(0, 3)];
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) r.req = REQ_UNUSED;
      else if (roll < 5) r = random_request();
      send_request(r);
      if ($urandom_range(0, 199) == 0) drain();
    end

    for (int k = 0; k < n_reads; k++) begin
      r     = random_request();
      r.req = REQ_READ;
      if (k == 0) r.seq = ref_id;
      else if ($urandom_range(0, 4) != 0) r.seq = pool[$urandom_range(0, 3)];
      send_request(r);
    end
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: idle_pct = 0;
      1: idle_pct = 5;
      2: idle_pct = 25;
      default: idle_pct = 60;
    endcase
    case ($urandom_range(0, 3))
      0: stall_pct = 0;
      1: stall_pct = 5;
      2: stall_pct = 25;
      default: stall_pct = 60;
    endcase
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reference('0);
    run_directed();

    // Random phases, each under its own reference id and idling mix; the
    // first two take the extreme ids.
    while (sent_count < RANDOM_ITEMS - QUIET_ITEMS) begin
      case (phase)
        0: write_reference('1);
        1: write_reference('0);
        default: write_reference(SEQ_BITS'($urandom));
      endcase
      pick_idling();
      repeat (2) run_column();
      phase++;
    end

    // Tail of the run: back-to-back traffic, receiver always ready.
    drain();
    idle_pct  = 0;
    stall_pct = 0;
    write_reference(SEQ_BITS'($urandom));
    while (sent_count < RANDOM_ITEMS) run_column();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d column passes under %0d reference settings.",
             sent_count, column_count, cfg_count);
    $display("Compared %0d result transactions field by field.", results_checked);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/clcp_pkg.sv
sv/clcp_front.sv
sv/clcp_queue.sv
sv/clcp_back.sv
sv/clcp_column_score_accumulator_top.sv
verif/clcp_column_score_checker.sv
verif/clcp_column_score_accumulator_top_tb.sv
